// File: design/lps_pkg.sv
package lps_pkg;
  localparam int unsigned SLOTS = 16;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned ID_W = 16;
  localparam int unsigned TKT_W = 8;
  localparam int unsigned POOL_W = 12;
  localparam int unsigned RND_W = 16;
  localparam int unsigned CNT_W = 5;

  typedef enum logic [2:0] {
    ACT_ADD     = 3'd0,
    ACT_BLOCK   = 3'd1,
    ACT_UNBLOCK = 3'd2,
    ACT_REMOVE  = 3'd3,
    ACT_PICK    = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_WAIT  = 3'd3,
    ST_BAD   = 3'd4
  } status_e;
endpackage

// File: design/lottery_process_scheduler.sv
// Lottery scheduler with a 16-slot ready table and a 16-slot blocked table.
// Assert start_i while busy_o is low to issue a request; exactly one result
// follows, shown for one cycle with done_o high, and the receiver cannot stall
// it. Add, block, unblock and remove pass through a read state, an execute
// state and a done state. A pick reads and decodes and, when a draw can be
// made, draws modulo the ticket pool (a restoring subtract loop, one quotient
// bit per cycle), walks over the ready slots (each slot waits for the registered
// table read, stopping at the winner), and then shows the result.
module lottery_process_scheduler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [2:0]                  action_i,
  input  logic [lps_pkg::ID_W-1:0]    proc_id_i,
  input  logic [lps_pkg::TKT_W-1:0]   tickets_i,
  input  logic [lps_pkg::SLOT_W-1:0]  blocked_slot_i,
  input  logic [lps_pkg::RND_W-1:0]   random_value_i,
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic [lps_pkg::SLOT_W-1:0]  slot_o,
  output logic [lps_pkg::ID_W-1:0]    chosen_id_o,
  output logic [11:0]                 ticket_drawn_o,
  output logic [11:0]                 total_tickets_o,
  output logic [5:0]                  process_count_o
);
  import lps_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_EXEC = 6'b000100,
    S_DIV  = 6'b001000,
    S_WALK = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [SLOTS-1:0] rvalid_q, bvalid_q;
  logic [ID_W-1:0]  rid_mem [SLOTS];
  logic [TKT_W-1:0] rtk_mem [SLOTS];
  logic [ID_W-1:0]  bid_mem [SLOTS];
  logic [TKT_W-1:0] btk_mem [SLOTS];
  logic             run_valid_q;
  logic [SLOT_W-1:0] run_slot_q;
  logic [POOL_W-1:0] pool_q;
  logic [CNT_W-1:0] rcnt_q, bcnt_q;

  logic [2:0]        act_q;
  logic [ID_W-1:0]   pid_q;
  logic [TKT_W-1:0]  tkt_q;
  logic [SLOT_W-1:0] bsl_q;
  logic [RND_W-1:0]  rem_q;
  logic [4:0]        step_q;
  logic [SLOT_W-1:0] walk_q;
  logic [POOL_W:0]   sum_q;

  // registered memory reads
  logic [ID_W-1:0]  rid_rd_q, bid_rd_q;
  logic [TKT_W-1:0] rtk_rd_q, btk_rd_q;
  logic [SLOT_W-1:0] rd_addr;

  logic [2:0]        st_q;
  logic [SLOT_W-1:0] oslot_q;
  logic [ID_W-1:0]   oid_q;
  logic [11:0]       odraw_q;

  // lowest free slot search
  logic              rfree_ok, bfree_ok;
  logic [SLOT_W-1:0] rfree, bfree;
  always_comb begin
    rfree_ok = 1'b0;
    rfree    = '0;
    bfree_ok = 1'b0;
    bfree    = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!rvalid_q[i]) begin
        rfree_ok = 1'b1;
        rfree    = SLOT_W'(i);
      end
      if (!bvalid_q[i]) begin
        bfree_ok = 1'b1;
        bfree    = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    case (state_q)
      S_WALK:  rd_addr = walk_q;
      default: rd_addr = run_slot_q;
    endcase
  end

  // one restoring subtract step of the draw modulo
  logic [POOL_W+RND_W-1:0] div_sub;
  logic [RND_W+POOL_W-1:0] rem_ext;
  logic [POOL_W+RND_W-1:0] shifted;
  logic [3:0] bitn;
  always_comb begin
    bitn    = 4'(4'd15 - step_q[3:0]);
    rem_ext = {{POOL_W{1'b0}}, rem_q};
    shifted = {{RND_W{1'b0}}, pool_q} << bitn;
    div_sub = rem_ext - shifted;
  end

  logic [POOL_W:0] walk_sum;
  logic            walk_hit, walk_last;
  assign walk_sum  = sum_q + (POOL_W+1)'(rtk_rd_q);
  assign walk_hit  = rvalid_q[walk_q] && (walk_sum > (POOL_W+1)'(rem_q[POOL_W-1:0]));
  assign walk_last = (walk_q == SLOT_W'(SLOTS - 1));

  always_ff @(posedge clk_i) begin
    rid_rd_q <= rid_mem[rd_addr];
    rtk_rd_q <= rtk_mem[rd_addr];
    bid_rd_q <= bid_mem[bsl_q];
    btk_rd_q <= btk_mem[bsl_q];
    if (state_q == S_EXEC) begin
      case (act_q)
        ACT_ADD: begin
          if (tkt_q != '0 && rfree_ok) begin
            rid_mem[rfree] <= pid_q;
            rtk_mem[rfree] <= tkt_q;
          end
        end
        ACT_BLOCK: begin
          if (run_valid_q && bfree_ok) begin
            bid_mem[bfree] <= rid_rd_q;
            btk_mem[bfree] <= rtk_rd_q;
          end
        end
        ACT_UNBLOCK: begin
          if (bvalid_q[bsl_q] && rfree_ok) begin
            rid_mem[rfree] <= bid_rd_q;
            rtk_mem[rfree] <= btk_rd_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start_i) state_d = S_READ;
      S_READ:  state_d = S_EXEC;
      S_EXEC: begin
        if (act_q == ACT_PICK && !(rcnt_q == '0 && !run_valid_q) && pool_q != '0) begin
          state_d = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV:   if (step_q == 5'd15) state_d = S_WALK;
      S_WALK:  if (step_q != 5'd16 && (walk_hit || walk_last)) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rvalid_q    <= '0;
      bvalid_q    <= '0;
      run_valid_q <= 1'b0;
      run_slot_q  <= '0;
      pool_q      <= '0;
      rcnt_q      <= '0;
      bcnt_q      <= '0;
      st_q        <= ST_OK;
      oslot_q     <= '0;
      oid_q       <= '0;
      odraw_q     <= '0;
      step_q      <= '0;
      walk_q      <= '0;
      sum_q       <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            act_q   <= action_i;
            pid_q   <= proc_id_i;
            tkt_q   <= tickets_i;
            bsl_q   <= blocked_slot_i;
            rem_q   <= random_value_i;
            st_q    <= ST_BAD;
            oslot_q <= '0;
            oid_q   <= '0;
            odraw_q <= '0;
          end
        end
        S_EXEC: begin
          case (act_q)
            ACT_ADD: begin
              if (tkt_q == '0) begin
                st_q <= ST_BAD;
              end else if (!rfree_ok) begin
                st_q <= ST_FULL;
              end else begin
                rvalid_q[rfree] <= 1'b1;
                rcnt_q  <= rcnt_q + 1'b1;
                pool_q  <= pool_q + POOL_W'(tkt_q);
                st_q    <= ST_OK;
                oslot_q <= rfree;
                oid_q   <= pid_q;
              end
            end
            ACT_BLOCK: begin
              if (!run_valid_q) begin
                st_q <= ST_BAD;
              end else if (!bfree_ok) begin
                st_q <= ST_FULL;
              end else begin
                rvalid_q[run_slot_q] <= 1'b0;
                pool_q      <= pool_q - POOL_W'(rtk_rd_q);
                bvalid_q[bfree] <= 1'b1;
                bcnt_q      <= bcnt_q + 1'b1;
                run_valid_q <= 1'b0;
                st_q    <= ST_OK;
                oslot_q <= bfree;
                oid_q   <= rid_rd_q;
              end
            end
            ACT_UNBLOCK: begin
              if (!bvalid_q[bsl_q]) begin
                st_q <= ST_BAD;
              end else if (!rfree_ok) begin
                st_q <= ST_FULL;
              end else begin
                bvalid_q[bsl_q] <= 1'b0;
                rvalid_q[rfree] <= 1'b1;
                pool_q  <= pool_q + POOL_W'(btk_rd_q);
                rcnt_q  <= rcnt_q + 1'b1;
                bcnt_q  <= bcnt_q - 1'b1;
                st_q    <= ST_OK;
                oslot_q <= rfree;
                oid_q   <= bid_rd_q;
              end
            end
            ACT_REMOVE: begin
              if (!run_valid_q) begin
                st_q <= ST_BAD;
              end else begin
                rvalid_q[run_slot_q] <= 1'b0;
                pool_q      <= pool_q - POOL_W'(rtk_rd_q);
                run_valid_q <= 1'b0;
                st_q    <= ST_OK;
                oslot_q <= run_slot_q;
                oid_q   <= rid_rd_q;
              end
            end
            ACT_PICK: begin
              if (run_valid_q) begin
                run_valid_q <= 1'b0;
              end
              if (rcnt_q == '0 && !run_valid_q) begin
                st_q <= (bcnt_q != '0) ? ST_WAIT : ST_EMPTY;
              end else if (pool_q == '0) begin
                rcnt_q <= rcnt_q + CNT_W'(run_valid_q);
                st_q   <= ST_EMPTY;
              end else begin
                rcnt_q <= rcnt_q + CNT_W'(run_valid_q);
                step_q <= '0;
              end
            end
            default: st_q <= ST_BAD;
          endcase
        end
        S_DIV: begin
          if (!div_sub[POOL_W+RND_W-1]) rem_q <= div_sub[RND_W-1:0];
          step_q <= step_q + 1'b1;
          walk_q <= '0;
          sum_q  <= '0;
        end
        S_WALK: begin
          // the table read is registered; step 16 waits for the read data to be valid
          if (step_q == 5'd16) begin
            step_q <= 5'd17;
            walk_q <= walk_q;
          end else begin
            if (walk_hit) begin
              rcnt_q      <= rcnt_q - 1'b1;
              run_valid_q <= 1'b1;
              run_slot_q  <= walk_q;
              st_q        <= ST_OK;
              oslot_q     <= walk_q;
              oid_q       <= rid_rd_q;
              odraw_q     <= rem_q[11:0];
            end else if (walk_last) begin
              st_q <= ST_EMPTY;
            end else begin
              if (rvalid_q[walk_q]) sum_q <= walk_sum;
              walk_q <= walk_q + 1'b1;
              step_q <= 5'd16;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = (state_q == S_DONE);
  assign status_o        = st_q;
  assign slot_o          = oslot_q;
  assign chosen_id_o     = oid_q;
  assign ticket_drawn_o  = odraw_q;
  assign total_tickets_o = pool_q;
  assign process_count_o = 6'(rcnt_q) + 6'(bcnt_q) + 6'(run_valid_q);
endmodule

// File: design/lps_checker.sv
module lps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [3:0]  slot_o,
  input logic [11:0] ticket_drawn_o,
  input logic [5:0]  process_count_o
);
  import lps_pkg::*;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done without busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("request not taken");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (slot_o == 4'd0 && ticket_drawn_o == 12'd0))
    else $error("fields not cleared on failure");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process_count_o <= 6'd32) else $error("count overflow");
endmodule

bind lottery_process_scheduler lps_checker u_lps_checker (.*);

// File: dv/sched_checker.sv
module sched_checker
  import lps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [2:0]        action_i,
  input  logic [ID_W-1:0]   proc_id_i,
  input  logic [TKT_W-1:0]  tickets_i,
  input  logic [SLOT_W-1:0] blocked_slot_i,
  input  logic [RND_W-1:0]  random_value_i,
  input  logic              done_i,
  input  logic [2:0]        status_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [ID_W-1:0]   chosen_id_i,
  input  logic [11:0]       ticket_drawn_i,
  input  logic [11:0]       total_tickets_i,
  input  logic [5:0]        process_count_i,
  output int                errors_o,
  output int                pending_o
);

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [11:0]       drawn;
    logic [11:0]       pool;
    logic [5:0]        count;
  } sched_result_t;

  logic              rdy_v [SLOTS];
  logic [ID_W-1:0]   rdy_id [SLOTS];
  logic [TKT_W-1:0]  rdy_t [SLOTS];
  logic              blk_v [SLOTS];
  logic [ID_W-1:0]   blk_id [SLOTS];
  logic [TKT_W-1:0]  blk_t [SLOTS];
  logic              run_v;
  logic [SLOT_W-1:0] run_slot;
  int unsigned       pool, n_ready, n_blocked;

  sched_result_t expected_q[$];

  function automatic int first_free(input logic v [SLOTS]);
    for (int i = 0; i < SLOTS; i++) if (!v[i]) return i;
    return -1;
  endfunction

  function automatic sched_result_t schedule(input logic [2:0] act, input logic [ID_W-1:0] pid,
                                             input logic [TKT_W-1:0] tk,
                                             input logic [SLOT_W-1:0] bs,
                                             input logic [RND_W-1:0] rnd);
    sched_result_t r;
    int s, b;
    int unsigned draw, sum;
    r = '0;
    r.status = ST_BAD;
    case (act)
      ACT_ADD: begin
        s = first_free(rdy_v);
        if (tk == 0) r.status = ST_BAD;
        else if (s < 0) r.status = ST_FULL;
        else begin
          rdy_v[s] = 1'b1; rdy_id[s] = pid; rdy_t[s] = tk;
          n_ready++; pool += tk;
          r.status = ST_OK; r.slot = SLOT_W'(s); r.id = pid;
        end
      end
      ACT_BLOCK: begin
        b = first_free(blk_v);
        if (!run_v) r.status = ST_BAD;
        else if (b < 0) r.status = ST_FULL;
        else begin
          rdy_v[run_slot] = 1'b0; pool -= rdy_t[run_slot];
          blk_v[b] = 1'b1; blk_id[b] = rdy_id[run_slot]; blk_t[b] = rdy_t[run_slot];
          n_blocked++; run_v = 1'b0;
          r.status = ST_OK; r.slot = SLOT_W'(b); r.id = blk_id[b];
        end
      end
      ACT_UNBLOCK: begin
        s = first_free(rdy_v);
        if (!blk_v[bs]) r.status = ST_BAD;
        else if (s < 0) r.status = ST_FULL;
        else begin
          blk_v[bs] = 1'b0; rdy_v[s] = 1'b1; rdy_id[s] = blk_id[bs]; rdy_t[s] = blk_t[bs];
          pool += blk_t[bs]; n_ready++; n_blocked--;
          r.status = ST_OK; r.slot = SLOT_W'(s); r.id = rdy_id[s];
        end
      end
      ACT_REMOVE: begin
        if (!run_v) r.status = ST_BAD;
        else begin
          rdy_v[run_slot] = 1'b0; pool -= rdy_t[run_slot]; run_v = 1'b0;
          r.status = ST_OK; r.slot = run_slot; r.id = rdy_id[run_slot];
        end
      end
      ACT_PICK: begin
        if (run_v) begin
          run_v = 1'b0; n_ready++;
        end
        if (n_ready == 0) r.status = (n_blocked > 0) ? ST_WAIT : ST_EMPTY;
        else if (pool == 0) r.status = ST_EMPTY;
        else begin
          draw = rnd % pool;
          sum = 0;
          r.status = ST_EMPTY;
          for (int i = 0; i < SLOTS; i++) begin
            if (rdy_v[i]) begin
              sum += rdy_t[i];
              if (sum > draw) begin
                n_ready--; run_v = 1'b1; run_slot = SLOT_W'(i);
                r.status = ST_OK; r.slot = SLOT_W'(i); r.id = rdy_id[i];
                r.drawn = 12'(draw);
                break;
              end
            end
          end
        end
      end
      default: r.status = ST_BAD;
    endcase
    r.pool = 12'(pool);
    r.count = 6'(n_ready + n_blocked + run_v);
    return r;
  endfunction

  assign pending_o = expected_q.size();

  task automatic compare(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t e;
    if (!rst_ni) begin
      errors_o = 0;
      run_v = 0; run_slot = 0; pool = 0; n_ready = 0; n_blocked = 0;
      for (int i = 0; i < SLOTS; i++) begin
        rdy_v[i] = 0; blk_v[i] = 0; rdy_id[i] = 0; rdy_t[i] = 0; blk_id[i] = 0; blk_t[i] = 0;
      end
      expected_q.delete();
    end else begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          errors_o++;
        end else begin
          e = expected_q.pop_front();
          compare("status", e.status, status_i);
          compare("slot", e.slot, slot_i);
          compare("chosen_id", e.id, chosen_id_i);
          compare("ticket_drawn", e.drawn, ticket_drawn_i);
          compare("total_tickets", e.pool, total_tickets_i);
          compare("process_count", e.count, process_count_i);
        end
      end
      if (start_i && !busy_i)
        expected_q.push_back(schedule(action_i, proc_id_i, tickets_i, blocked_slot_i,
                                      random_value_i));
    end
  end

endmodule

// File: dv/testbench.sv
module testbench;
  import lps_pkg::*;

  localparam int N_RANDOM = 800;
  localparam int STALL_LIMIT = 2000;

  logic              clk_i, rst_ni, start_i, busy_o, done_o;
  logic [2:0]        action_i, status_o;
  logic [ID_W-1:0]   proc_id_i, chosen_id_o;
  logic [TKT_W-1:0]  tickets_i;
  logic [SLOT_W-1:0] blocked_slot_i, slot_o;
  logic [RND_W-1:0]  random_value_i;
  logic [11:0]       ticket_drawn_o, total_tickets_o;
  logic [5:0]        process_count_o;
  int                errors, pending, idle_cycles;

  lottery_process_scheduler dut (.*);

  sched_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .action_i, .proc_id_i, .tickets_i,
    .blocked_slot_i, .random_value_i, .done_i(done_o), .status_i(status_o),
    .slot_i(slot_o), .chosen_id_i(chosen_id_o), .ticket_drawn_i(ticket_drawn_o),
    .total_tickets_i(total_tickets_o), .process_count_i(process_count_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // count cycles with no request taken and no result shown
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // hold start until the request is taken; the caller drops start
  task automatic issue(input action_e act, input logic [ID_W-1:0] pid,
                       input logic [TKT_W-1:0] tk, input logic [SLOT_W-1:0] bs,
                       input logic [RND_W-1:0] rnd);
    start_i <= 1; action_i <= act; proc_id_i <= pid; tickets_i <= tk;
    blocked_slot_i <= bs; random_value_i <= rnd;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic gap(input bit quiet);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start_i <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  initial begin
    int a;
    start_i = 0; action_i = 0; proc_id_i = 0; tickets_i = 0;
    blocked_slot_i = 0; random_value_i = 0; idle_cycles = 0;
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // empty table, bad codes, zero tickets, no running process
    issue(ACT_PICK, 0, 0, 0, 16'hFFFF);
    issue(ACT_BLOCK, 0, 0, 0, 0);
    issue(ACT_REMOVE, 0, 0, 0, 0);
    issue(ACT_UNBLOCK, 0, 0, 4'hF, 0);
    issue(ACT_ADD, 16'hFFFF, 0, 0, 0);
    issue(action_e'(3'd5), 0, 0, 0, 0);
    issue(action_e'(3'd7), 16'hFFFF, 8'hFF, 4'hF, 16'hFFFF);
    // fill the ready table and overflow it
    for (int i = 0; i < 17; i++)
      issue(ACT_ADD, 16'(i * 16'h0F0F), (i == 0) ? 8'h01 : 8'hFF, 0, 0);
    issue(ACT_PICK, 0, 0, 0, 16'hFFFF);
    issue(ACT_BLOCK, 0, 0, 0, 0);
    issue(ACT_PICK, 0, 0, 0, 0);
    issue(ACT_REMOVE, 0, 0, 0, 0);
    issue(ACT_UNBLOCK, 0, 0, 0, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      bit quiet;
      quiet = n > N_RANDOM - 100;
      gap(quiet);
      a = $urandom_range(0, 99);
      if (a < 3) issue(action_e'($urandom_range(5, 7)), 16'($urandom), 8'($urandom),
                       4'($urandom), 16'($urandom));
      else if (a < 28) issue(ACT_ADD, 16'($urandom), ($urandom_range(0, 20) == 0) ? 8'd0 :
                            8'($urandom_range(1, 255)), 4'($urandom), 16'($urandom));
      else if (a < 43) issue(ACT_BLOCK, 16'($urandom), 8'($urandom), 4'($urandom),
                             16'($urandom));
      else if (a < 60) issue(ACT_UNBLOCK, 16'($urandom), 8'($urandom),
                             4'($urandom_range(0, 15)), 16'($urandom));
      else if (a < 70) issue(ACT_REMOVE, 16'($urandom), 8'($urandom), 4'($urandom),
                             16'($urandom));
      else issue(ACT_PICK, 16'($urandom), 8'($urandom), 4'($urandom), 16'($urandom));
    end
    start_i <= 0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
design/lps_pkg.sv
design/lottery_process_scheduler.sv
design/lps_checker.sv
dv/sched_checker.sv
dv/testbench.sv
